FILE: hw/rtl/rfmc_pkg.sv
package rfmc_pkg;

    localparam int DEPTH   = 256;
    localparam int ITEM_W  = 32;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int PTR_W   = ADDR_W + 1;
    localparam int LG_W    = 4;
    localparam int ACT_W   = 3;
    localparam int STAT_W  = 2;

    localparam logic [ACT_W-1:0] ACT_PUT      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_GET      = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PEEK     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CONTAINS = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FLUSH    = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    localparam logic [LG_W-1:0] CAP_LG_RESET = 4'd8;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [ITEM_W-1:0] item_data;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ITEM_W-1:0] read_data;
        logic [PTR_W-1:0]  match_count;
        logic [PTR_W-1:0]  fill_level;
        logic [PTR_W-1:0]  free_space;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

endpackage

FILE: hw/rtl/ring_fifo_with_match_count.sv
// Ring-buffer FIFO of up to 256 32-bit items in one synchronous RAM, capacity
// 2^capacity_log2 (values above 8 act as 8). Put, get, peek and flush need no
// scan and may follow back to back; each beat yields one result beat, and
// the result register lets a new beat in while the previous result is taken.
// Contains reads the held entries one per cycle through the single RAM read
// port, so it occupies the block while it scans (no scan when empty) and holds
// off input beats meanwhile. Write capacity_log2 only while idle, and flush
// before changing it while items are held.
module ring_fifo_with_match_count (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  rfmc_pkg::t_in               i_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output rfmc_pkg::t_out              o_result,
    input  logic                        i_cfg_wr_en,
    input  logic [rfmc_pkg::LG_W-1:0]   i_cfg_wr_data
);

    localparam int A = rfmc_pkg::ADDR_W;
    localparam int P = rfmc_pkg::PTR_W;

    rfmc_pkg::t_state          r_state, n_state;
    logic [rfmc_pkg::LG_W-1:0] r_cap_lg;
    logic [P-1:0]              r_rptr, n_rptr;
    logic [P-1:0]              r_wptr, n_wptr;
    logic [P-1:0]              r_issued, n_issued;
    logic [P-1:0]              r_n, n_n;
    logic [P-1:0]              r_cnt, n_cnt;
    logic [rfmc_pkg::ITEM_W-1:0] r_key;
    logic                      r_out_valid, n_out_valid;
    logic                      r_use_q, n_use_q;
    rfmc_pkg::t_out            r_out, n_out;

    logic [rfmc_pkg::LG_W-1:0] cap_lg;
    logic [P-1:0]              cap;
    logic [A-1:0]              cmask;
    logic [P-1:0]              fill, new_fill, new_free;
    logic                      full, empty, accept, scan_more;
    logic                      wr_en, rd_en;
    logic [A-1:0]              wr_addr, rd_addr;
    logic [rfmc_pkg::ITEM_W-1:0] rd_data;
    logic [rfmc_pkg::STAT_W-1:0] status;

    rfmc_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_item.item_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign cap_lg = (r_cap_lg > rfmc_pkg::LG_W'(A)) ? rfmc_pkg::LG_W'(A) : r_cap_lg;
    assign cap    = P'(1) << cap_lg;
    assign cmask  = A'(cap - P'(1));
    assign fill   = r_wptr - r_rptr;
    assign full   = fill >= cap;
    assign empty  = fill == '0;

    assign o_in_ready = (r_state == rfmc_pkg::ST_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign scan_more  = r_issued < r_n;

    assign wr_en   = accept && (i_item.action == rfmc_pkg::ACT_PUT) && !full;
    assign wr_addr = r_wptr[A-1:0] & cmask;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_rptr[A-1:0] & cmask;
        if (r_state == rfmc_pkg::ST_SCAN) begin
            rd_en   = scan_more;
            rd_addr = (r_rptr[A-1:0] + r_issued[A-1:0]) & cmask;
        end else if (accept && !empty) begin
            rd_en = (i_item.action == rfmc_pkg::ACT_GET)
                 || (i_item.action == rfmc_pkg::ACT_PEEK)
                 || (i_item.action == rfmc_pkg::ACT_CONTAINS);
        end
    end

    always_comb begin
        n_rptr = r_rptr;
        n_wptr = r_wptr;
        status = rfmc_pkg::STAT_OK;
        case (i_item.action)
            rfmc_pkg::ACT_PUT: begin
                if (full) begin
                    status = rfmc_pkg::STAT_FULL;
                end else if (accept) begin
                    n_wptr = r_wptr + P'(1);
                end
            end
            rfmc_pkg::ACT_GET: begin
                if (empty) begin
                    status = rfmc_pkg::STAT_EMPTY;
                end else if (accept) begin
                    n_rptr = r_rptr + P'(1);
                end
            end
            rfmc_pkg::ACT_PEEK: begin
                if (empty) begin
                    status = rfmc_pkg::STAT_EMPTY;
                end
            end
            rfmc_pkg::ACT_FLUSH: begin
                if (accept) begin
                    n_rptr = '0;
                    n_wptr = '0;
                end
            end
            default: begin
            end
        endcase
        new_fill = n_wptr - n_rptr;
        new_free = (new_fill >= cap) ? '0 : cap - new_fill;
    end

    always_comb begin
        n_state     = r_state;
        n_issued    = r_issued;
        n_n         = r_n;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_use_q     = r_use_q;
        n_out       = r_out;
        case (r_state)
            rfmc_pkg::ST_IDLE: begin
                if (accept) begin
                    if ((i_item.action == rfmc_pkg::ACT_CONTAINS) && !empty) begin
                        n_state     = rfmc_pkg::ST_SCAN;
                        n_issued    = P'(1);
                        n_n         = fill;
                        n_cnt       = '0;
                        n_out_valid = 1'b0;
                    end else begin
                        n_out_valid          = 1'b1;
                        n_use_q              = !empty
                            && ((i_item.action == rfmc_pkg::ACT_GET)
                             || (i_item.action == rfmc_pkg::ACT_PEEK));
                        n_out.status         = status;
                        n_out.read_data      = '0;
                        n_out.match_count    = '0;
                        n_out.fill_level     = new_fill;
                        n_out.free_space     = new_free;
                    end
                end
            end
            rfmc_pkg::ST_SCAN: begin
                n_cnt = r_cnt + P'(rd_data == r_key);
                if (scan_more) begin
                    n_issued = r_issued + P'(1);
                end else begin
                    n_state           = rfmc_pkg::ST_IDLE;
                    n_out_valid       = 1'b1;
                    n_use_q           = 1'b0;
                    n_out.status      = rfmc_pkg::STAT_OK;
                    n_out.read_data   = '0;
                    n_out.match_count = n_cnt;
                    n_out.fill_level  = fill;
                    n_out.free_space  = full ? '0 : cap - fill;
                end
            end
            default: begin
                n_state = rfmc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rfmc_pkg::ST_IDLE;
            r_cap_lg    <= rfmc_pkg::CAP_LG_RESET;
            r_rptr      <= '0;
            r_wptr      <= '0;
            r_issued    <= '0;
            r_n         <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_use_q     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rptr      <= n_rptr;
            r_wptr      <= n_wptr;
            r_issued    <= n_issued;
            r_n         <= n_n;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_use_q     <= n_use_q;
            if (i_cfg_wr_en) begin
                r_cap_lg <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (accept) begin
            r_key <= i_item.item_data;
        end
    end

    always_comb begin
        o_result = r_out;
        if (r_use_q) begin
            o_result.read_data = rd_data;
        end
    end

    assign o_out_valid = r_out_valid;

    a_scan_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rfmc_pkg::ST_SCAN) |-> !o_in_ready)
        else $error("input beat taken during contains scan");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill <= P'(rfmc_pkg::DEPTH))
        else $error("fill level beyond store depth");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !((i_item.action == rfmc_pkg::ACT_CONTAINS) && !empty))
        |=> o_out_valid)
        else $error("no result after single-cycle beat");

    a_scan_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rfmc_pkg::ST_SCAN) |-> !o_out_valid)
        else $error("result pending during scan");

endmodule

FILE: hw/rtl/rfmc_store.sv
module rfmc_store (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [rfmc_pkg::ADDR_W-1:0]  i_wr_addr,
    input  logic [rfmc_pkg::ITEM_W-1:0]  i_wr_data,
    input  logic                         i_rd_en,
    input  logic [rfmc_pkg::ADDR_W-1:0]  i_rd_addr,
    output logic [rfmc_pkg::ITEM_W-1:0]  o_rd_data
);

    logic [rfmc_pkg::ITEM_W-1:0] r_mem [rfmc_pkg::DEPTH];
    logic [rfmc_pkg::ITEM_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold the last read word until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

FILE: tb/sv/ring_fifo_with_match_count_test.sv
`timescale 1ns / 1ps

module ring_fifo_with_match_count_test;
    import rfmc_pkg::*;

    localparam logic [ACT_W-1:0] ACT_SPARE_5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int REPORT_MAX = 10;
    localparam int HOLD_OFF_CYCLES = 300;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in               i_item;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out              o_result;
    logic              i_cfg_wr_en;
    logic [LG_W-1:0]   i_cfg_wr_data;

    ring_fifo_with_match_count dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_item        (i_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result      (o_result),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    logic [ITEM_W-1:0] ring_items [DEPTH];
    bit                ring_written [DEPTH];
    logic [PTR_W-1:0]  rd_ptr;
    logic [PTR_W-1:0]  wr_ptr;
    logic [LG_W-1:0]   cap_lg;
    t_out              owed_results [$];
    logic [ITEM_W-1:0] data_pool [4];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    bit hold_req;
    int cycle_count;
    int mismatch_count;
    int beats_sent;
    int results_seen;
    int cfg_writes;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int unsigned ring_capacity();
        int unsigned c;
        int i;
        c = 1;
        for (i = 0; i < int'(cap_lg); i++) begin
            if (c * 2 > DEPTH) break;
            c = c * 2;
        end
        return c;
    endfunction

    function automatic int unsigned ring_fill();
        logic [PTR_W-1:0] d;
        d = wr_ptr - rd_ptr;
        return 32'(d);
    endfunction

    function automatic bit reads_defined(input logic [ACT_W-1:0] act);
        int unsigned n;
        int unsigned cmask;
        int unsigned i;
        logic [PTR_W-1:0] p;
        n = ring_fill();
        cmask = ring_capacity() - 1;
        if (act == ACT_GET || act == ACT_PEEK) begin
            n = (n > 0) ? 1 : 0;
        end else if (act != ACT_CONTAINS) begin
            return 1'b1;
        end
        for (i = 0; i < n; i++) begin
            p = rd_ptr + PTR_W'(i);
            if (!ring_written[p & cmask]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_out apply_ring_action(input t_in it);
        t_out r;
        int unsigned cap;
        int unsigned cmask;
        int unsigned n;
        int unsigned f;
        int unsigned i;
        logic [PTR_W-1:0] p;
        cap = ring_capacity();
        cmask = cap - 1;
        n = ring_fill();
        r = '0;
        r.status = STAT_OK;
        case (it.action)
            ACT_PUT: begin
                if (n >= cap) begin
                    r.status = STAT_FULL;
                end else begin
                    ring_items[wr_ptr & cmask] = it.item_data;
                    ring_written[wr_ptr & cmask] = 1'b1;
                    wr_ptr = wr_ptr + 1'b1;
                end
            end
            ACT_GET, ACT_PEEK: begin
                if (n == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.read_data = ring_items[rd_ptr & cmask];
                    if (it.action == ACT_GET) rd_ptr = rd_ptr + 1'b1;
                end
            end
            ACT_CONTAINS: begin
                for (i = 0; i < n; i++) begin
                    p = rd_ptr + PTR_W'(i);
                    if (ring_items[p & cmask] == it.item_data)
                        r.match_count = r.match_count + 1'b1;
                end
            end
            ACT_FLUSH: begin
                rd_ptr = '0;
                wr_ptr = '0;
            end
            default: ;
        endcase
        f = ring_fill();
        r.fill_level = PTR_W'(f);
        r.free_space = (f >= cap) ? '0 : PTR_W'(cap - f);
        return r;
    endfunction

    task automatic note_mismatch(input string what, input t_out want, input t_out got);
        if (mismatch_count < REPORT_MAX) begin
            $write("%s result #%0d: expected st=%0d rd=%h mc=%0d fl=%0d fr=%0d, ",
                what, results_seen, want.status, want.read_data, want.match_count,
                want.fill_level, want.free_space);
            $display("got st=%0d rd=%h mc=%0d fl=%0d fr=%0d", got.status, got.read_data,
                got.match_count, got.fill_level, got.free_space);
        end
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (owed_results.size() == 0) begin
                note_mismatch("Unexpected", '0, o_result);
            end else begin
                want = owed_results.pop_front();
                if (o_result.status !== want.status ||
                    o_result.read_data !== want.read_data ||
                    o_result.match_count !== want.match_count ||
                    o_result.fill_level !== want.fill_level ||
                    o_result.free_space !== want.free_space)
                    note_mismatch("Wrong", want, o_result);
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_cycles = HOLD_OFF_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            hold_cycles--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_beat(input logic [ACT_W-1:0] act, input logic [ITEM_W-1:0] data);
        t_in it;
        it.action = act;
        it.item_data = data;
        // never touch a store entry that was not written yet
        if (!reads_defined(act)) it.action = ACT_FLUSH;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        owed_results.push_back(apply_ring_action(it));
        i_in_valid <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (owed_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [LG_W-1:0] lg);
        drain_results();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= lg;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cap_lg = lg;
        cfg_writes++;
        @(negedge i_clk);
    endtask

    function automatic logic [ACT_W-1:0] pick_action();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40) return ACT_PUT;
        if (r < 70) return ACT_GET;
        if (r < 80) return ACT_PEEK;
        if (r < 92) return ACT_CONTAINS;
        if (r < 96) return ACT_FLUSH;
        if (r < 97) return ACT_SPARE_5;
        if (r < 98) return ACT_SPARE_6;
        return ACT_SPARE_7;
    endfunction

    function automatic logic [ITEM_W-1:0] pick_data();
        if ($urandom_range(1)) return data_pool[$urandom_range(3)];
        return $urandom();
    endfunction

    task automatic test_empty_and_extremes();
        write_capacity(CAP_LG_RESET);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_beat(ACT_GET, '0);
        send_beat(ACT_PEEK, '0);
        send_beat(ACT_CONTAINS, '0);
        send_beat(ACT_PUT, '0);
        send_beat(ACT_PUT, '1);
        send_beat(ACT_PUT, '0);
        send_beat(ACT_PEEK, '0);
        send_beat(ACT_CONTAINS, '0);
        send_beat(ACT_CONTAINS, '1);
        send_beat(ACT_SPARE_5, '1);
        send_beat(ACT_SPARE_6, '0);
        send_beat(ACT_SPARE_7, '1);
        send_beat(ACT_GET, '0);
        send_beat(ACT_GET, '0);
        send_beat(ACT_GET, '0);
        send_beat(ACT_GET, '0);
        send_beat(ACT_PUT, 32'h8000_0001);
        send_beat(ACT_FLUSH, '1);
        send_beat(ACT_PEEK, '0);
        drain_results();
    endtask

    task automatic test_capacity_one();
        write_capacity(4'd0);
        send_beat(ACT_PUT, 32'hA5A5_5A5A);
        send_beat(ACT_PUT, 32'h5A5A_A5A5);
        send_beat(ACT_PEEK, '0);
        send_beat(ACT_CONTAINS, 32'hA5A5_5A5A);
        send_beat(ACT_GET, '0);
        send_beat(ACT_GET, '0);
        send_beat(ACT_PUT, $urandom());
        send_beat(ACT_FLUSH, '0);
        drain_results();
    endtask

    task automatic test_shrink_while_held();
        write_capacity(4'd3);
        send_beat(ACT_FLUSH, '0);
        repeat (8) send_beat(ACT_PUT, pick_data());
        send_beat(ACT_PUT, $urandom());
        write_capacity(4'd2);
        send_beat(ACT_PUT, $urandom());
        send_beat(ACT_CONTAINS, data_pool[0]);
        send_beat(ACT_PEEK, '0);
        repeat (5) send_beat(ACT_GET, '0);
        send_beat(ACT_PUT, $urandom());
        send_beat(ACT_CONTAINS, pick_data());
        send_beat(ACT_PUT, $urandom());
        // grow with items held
        write_capacity(4'd5);
        send_beat(ACT_GET, '0);
        send_beat(ACT_CONTAINS, pick_data());
        send_beat(ACT_FLUSH, '0);
        drain_results();
    endtask

    task automatic test_full_depth();
        logic [ITEM_W-1:0] fill_word;
        fill_word = $urandom();
        write_capacity(4'd15);
        send_idle_pct = 7;
        recv_stall_pct = 7;
        send_beat(ACT_FLUSH, '0);
        repeat (DEPTH) send_beat(ACT_PUT, fill_word);
        send_beat(ACT_PUT, ~fill_word);
        send_beat(ACT_CONTAINS, fill_word);
        send_beat(ACT_CONTAINS, ~fill_word);
        send_beat(ACT_PEEK, '0);
        repeat (20) send_beat($urandom_range(1) ? ACT_GET : ACT_PUT, $urandom());
        send_beat(ACT_CONTAINS, fill_word);
        send_beat(ACT_FLUSH, '0);
        drain_results();
    endtask

    task automatic test_output_hold_off();
        write_capacity(4'd2);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b1;
        repeat (24) send_beat($urandom_range(2) ? ACT_PUT : ACT_GET, pick_data());
        send_beat(ACT_CONTAINS, pick_data());
        drain_results();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [LG_W-1:0] lg, input int count);
        write_capacity(lg);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_beat(pick_action(), pick_data());
        drain_results();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_item = '0;
        i_out_ready = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        rd_ptr = '0;
        wr_ptr = '0;
        cap_lg = CAP_LG_RESET;
        data_pool[0] = '0;
        data_pool[1] = '1;
        data_pool[2] = $urandom();
        data_pool[3] = $urandom();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_and_extremes();
        test_capacity_one();
        test_shrink_while_held();
        test_full_depth();
        test_output_hold_off();
        test_random_traffic(0, 0, 4'd2, 60);
        test_random_traffic(86, 0, 4'($urandom_range(3, 5)), 60);
        test_random_traffic(0, 86, 4'd8, 60);
        test_random_traffic(7, 7, 4'd1, 60);
        test_random_traffic(7, 7, 4'($urandom_range(9, 15)), 40);

        drain_results();
        repeat (20) @(negedge i_clk);
        $display("Run: %0d input beats, %0d results, %0d capacity writes", beats_sent,
            results_seen, cfg_writes);
        $display("Covered empty/full edges, resize with items held, full depth, long hold-off");
        if (mismatch_count == 0 && owed_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d bad results, %0d still owed", mismatch_count, owed_results.size());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
